@@ sv/uart8_pkg.sv @@
// Shared types and constants of the 8N1 UART transceiver.
// No dependencies; used by uart8_tx, uart8_rx and uart_8n1_transceiver_unit.
package uart8_pkg;

	localparam int TICK_W          = 17;
	localparam int BYTE_W          = 8;
	localparam int DATA_BITS_DEF   = 8;
	localparam logic [TICK_W-1:0] BIT_TICKS_RESET = 17'd104000;

	// stream payload widths, packed up to whole bytes
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	// transmitter status for one tick
	typedef struct packed {
		logic level;
		logic busy;
		logic accepted;
	} tx_res_t;

	// receiver status for one tick
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              valid;
	} rx_res_t;

endpackage

@@ sv/uart8_tx.sv @@
// Transmit side of the 8N1 UART: phase, bit timer and shift register.
// Depends on uart8_pkg.
module uart8_tx #(
	parameter int DATA_BITS = uart8_pkg::DATA_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [uart8_pkg::TICK_W-1:0] period,
	input  logic                         action,
	input  logic [uart8_pkg::BYTE_W-1:0] tx_data,
	output uart8_pkg::tx_res_t           res
);
	import uart8_pkg::*;

	localparam int PHASE_W = $clog2(DATA_BITS + 4);
	localparam logic [PHASE_W-1:0] PH_IDLE  = '0;
	localparam logic [PHASE_W-1:0] PH_START = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PH_STOP  = PHASE_W'(DATA_BITS + 2);

	logic [PHASE_W-1:0] phase_q, phase_n;
	logic [TICK_W-1:0]  timer_q, timer_n;
	logic [BYTE_W-1:0]  shift_q, shift_n;
	logic               accepted;
	logic               level;
	logic [PHASE_W-1:0] idx;

	// advance the phase and the bit timer, then take a new byte when idle
	always_comb begin
		phase_n  = phase_q;
		timer_n  = timer_q;
		shift_n  = shift_q;
		accepted = 1'b0;
		if (phase_q != PH_IDLE) begin
			if (timer_q != '0) begin
				timer_n = timer_q - TICK_W'(1);
			end
			if (timer_n == '0) begin
				if (phase_q >= PH_STOP) begin
					phase_n = PH_IDLE;
				end else begin
					phase_n = phase_q + PHASE_W'(1);
					timer_n = period;
				end
			end
		end
		if (phase_n == PH_IDLE && action) begin
			shift_n  = tx_data;
			phase_n  = PH_START;
			timer_n  = period;
			accepted = 1'b1;
		end
	end

	// line level for the updated phase
	assign idx = phase_n - PHASE_W'(2);
	always_comb begin
		if (phase_n == PH_IDLE || phase_n >= PH_STOP) begin
			level = 1'b1;
		end else if (phase_n == PH_START) begin
			level = 1'b0;
		end else if ({1'b0, idx} >= (PHASE_W + 1)'(BYTE_W)) begin
			level = 1'b0;
		end else begin
			level = shift_n[idx[2:0]];
		end
	end
	assign res.level    = level;
	assign res.busy     = (phase_n != PH_IDLE);
	assign res.accepted = accepted;

	// hold state unless a tick is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			timer_q <= timer_n;
			shift_q <= shift_n;
		end
	end

endmodule

@@ sv/uart8_rx.sv @@
// Receive side of the 8N1 UART: start detect, bit timer and shift register.
// Depends on uart8_pkg.
module uart8_rx #(
	parameter int DATA_BITS = uart8_pkg::DATA_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [uart8_pkg::TICK_W-1:0] period,
	input  logic                         rx_level,
	output uart8_pkg::rx_res_t           res
);
	import uart8_pkg::*;

	localparam int CNT_W = $clog2(DATA_BITS + 1);

	logic              active_q, active_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic [TICK_W-1:0] timer_q, timer_n;
	logic [BYTE_W-1:0] shift_q, shift_n;

	// sample at each bit time, report at the stop bit time, then rearm
	always_comb begin
		active_n  = active_q;
		cnt_n     = cnt_q;
		timer_n   = timer_q;
		shift_n   = shift_q;
		res.valid = 1'b0;
		res.data  = '0;
		if (active_q) begin
			if (timer_q != '0) begin
				timer_n = timer_q - TICK_W'(1);
			end
			if (timer_n == '0) begin
				if ({1'b0, cnt_q} < (CNT_W + 1)'(DATA_BITS)) begin
					if ({1'b0, cnt_q} < (CNT_W + 1)'(BYTE_W)) begin
						shift_n = shift_q | (BYTE_W'(rx_level) << cnt_q[2:0]);
					end
					cnt_n   = cnt_q + CNT_W'(1);
					timer_n = period;
				end else begin
					res.valid = 1'b1;
					res.data  = shift_q;
					active_n  = 1'b0;
				end
			end
		end
		if (!active_n && !rx_level) begin
			active_n = 1'b1;
			cnt_n    = '0;
			shift_n  = '0;
			timer_n  = period;
		end
	end

	// hold state unless a tick is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			timer_q  <= '0;
			shift_q  <= '0;
		end else if (step) begin
			active_q <= active_n;
			cnt_q    <= cnt_n;
			timer_q  <= timer_n;
			shift_q  <= shift_n;
		end
	end

endmodule

@@ sv/uart_8n1_transceiver_unit.sv @@
// Top level of the 8N1 UART transceiver: input register, tx/rx cores, result register.
// Depends on uart8_pkg, uart8_tx and uart8_rx.
//
//  port group   dir  payload
//  s_axis       in   tuser: action; tdata: tx_data[7:0], rx_level[8]
//  m_axis       out  tuser: rx_valid; tdata: tx_level, tx_busy, tx_accepted, rx_data[10:3]
//  cfg          in   cfg_wdata: bit_ticks (17 bits)
//
// Each item is one time-base tick; one item enters every cycle unless the result
// register stalls, and passes the input register, then the result register.
// Both line state machines advance only when an item moves from the input
// register to the result register; a stalled result register holds them.
// Reset clears both cores to idle and bit_ticks to 104000.
module uart_8n1_transceiver_unit #(
	parameter int DATA_BITS = uart8_pkg::DATA_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// bit 0: tx_data[7:0] in [7:0], rx_level in [8], zero fill above
	input  logic [uart8_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// bit 0: action
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tx_level [0], tx_busy [1], tx_accepted [2], rx_data [10:3], zero fill above
	output logic [uart8_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// bit 0: rx_valid
	output logic                              m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [uart8_pkg::TICK_W-1:0]      cfg_wdata
);
	import uart8_pkg::*;

	logic [TICK_W-1:0] bit_ticks_q;
	logic [TICK_W-1:0] period;

	logic              valid_s1;
	logic              action_s1;
	logic [BYTE_W-1:0] tx_data_s1;
	logic              rx_level_s1;

	logic              valid_s2;
	tx_res_t           tx_res, tx_res_s2;
	rx_res_t           rx_res, rx_res_s2;

	logic              advance;

	// bit period register; zero counts as one tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= BIT_TICKS_RESET;
		end else if (cfg_we) begin
			bit_ticks_q <= cfg_wdata;
		end
	end
	assign period = (bit_ticks_q == '0) ? TICK_W'(1) : bit_ticks_q;

	// move an item forward when the result register is free or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1   <= s_axis_tuser;
			tx_data_s1  <= s_axis_tdata[BYTE_W-1:0];
			rx_level_s1 <= s_axis_tdata[BYTE_W];
		end
	end

	uart8_tx #(.DATA_BITS(DATA_BITS)) u_tx (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.period  (period),
		.action  (action_s1),
		.tx_data (tx_data_s1),
		.res     (tx_res)
	);

	uart8_rx #(.DATA_BITS(DATA_BITS)) u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.period   (period),
		.rx_level (rx_level_s1),
		.res      (rx_res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (advance) begin
			tx_res_s2 <= tx_res;
			rx_res_s2 <= rx_res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = rx_res_s2.valid;
	assign m_axis_tdata  = {(OUT_TDATA_W - BYTE_W - 3)'(0), rx_res_s2.data,
		tx_res_s2.accepted, tx_res_s2.busy, tx_res_s2.level};

endmodule
